// File: sv/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types, constants and speed tables for the star field plotter.
// ----------------------------------------------------------------------------
`default_nettype none

package sfp_pkg;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_BLINK_A    = 3'd0;
  localparam logic [2:0] REG_BLINK_B    = 3'd1;
  localparam logic [2:0] REG_SPEED_SEL  = 3'd2;
  localparam logic [2:0] REG_FLIP       = 3'd3;
  localparam logic [2:0] REG_CLIP_MIN_X = 3'd4;
  localparam logic [2:0] REG_CLIP_MAX_X = 3'd5;
  localparam logic [2:0] REG_CLIP_MIN_Y = 3'd6;
  localparam logic [2:0] REG_CLIP_MAX_Y = 3'd7;

  localparam logic [8:0] CLIP_MAX_X_RST = 9'd383;
  localparam logic [7:0] CLIP_MAX_Y_RST = 8'd255;

  localparam logic [7:0] VISIBLE_LIMIT = 8'd224;
  localparam logic [8:0] FLIP_OFFSET   = 9'd160;
  localparam logic [9:0] PEN_BASE      = 10'd516;

  localparam logic MODE_STAR = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic       blink_a;
    logic       blink_b;
    logic [5:0] speed_select;
    logic       flip;
    logic [8:0] clip_min_x;
    logic [8:0] clip_max_x;
    logic [7:0] clip_min_y;
    logic [7:0] clip_max_y;
  } sfp_cfg_t;

  // signed speeds as 8-bit two's complement
  function automatic logic [7:0] speed_x(input logic [2:0] sel);
    logic [7:0] v;
    case (sel)
      3'd0:    v = 8'hFF;
      3'd1:    v = 8'hFE;
      3'd2:    v = 8'hFD;
      3'd3:    v = 8'h00;
      3'd4:    v = 8'h03;
      3'd5:    v = 8'h02;
      3'd6:    v = 8'h01;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] speed_y(input logic [2:0] sel);
    logic [7:0] v;
    case (sel)
      3'd0:    v = 8'h00;
      3'd1:    v = 8'hFF;
      3'd2:    v = 8'hFE;
      3'd3:    v = 8'hFD;
      3'd4:    v = 8'h00;
      3'd5:    v = 8'h03;
      3'd6:    v = 8'h02;
      default: v = 8'h01;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: sv/star_field_plotter.sv
// ----------------------------------------------------------------------------
// star_field_plotter
// Scrolling star field: vblank ticks move the scroll, star entries become
// clipped pixels with a pen number.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake      | payload
//  ---------+-----------+----------------+------------------------------------
//  in_      | in        | valid / stall  | mode, star_x, star_y, star_set,
//           |           |                | star_color
//  out_     | out       | valid / stall  | pixel_valid, pixel_x, pixel_y,
//           |           |                | pixel_color
//  cfg      | in        | APB, pready=1  | 8 registers at 4*index
//
// One item per cycle while in_stall is low; one result per item, registered in the cycle after acceptance.
// The only register on the item path is the single result register after the plot logic.
// in_stall is high while the result register holds an item that is stalled.
// Synchronous active-low reset clears scroll and out_valid and sets the registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module star_field_plotter (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_mode,
  input  wire logic [7:0]                in_star_x,
  input  wire logic [7:0]                in_star_y,
  input  wire logic [1:0]                in_star_set,
  input  wire logic [5:0]                in_star_color,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_pixel_valid,
  output logic      [8:0]                out_pixel_x,
  output logic      [7:0]                out_pixel_y,
  output logic      [9:0]                out_pixel_color,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [sfp_pkg::AddrW-1:0] paddr,
  input  wire logic [sfp_pkg::DataW-1:0] pwdata,
  output logic      [sfp_pkg::DataW-1:0] prdata,
  output logic                           pready
);

  sfp_pkg::sfp_cfg_t cfg;

  sfp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic       accept;
  logic [7:0] scroll_x_r, scroll_x_nxt;
  logic [7:0] scroll_y_r, scroll_y_nxt;
  logic       out_valid_r;
  logic       pix_valid_r, pix_valid_nxt;
  logic [8:0] pix_x_r, pix_x_nxt;
  logic [7:0] pix_y_r, pix_y_nxt;
  logic [9:0] pix_col_r, pix_col_nxt;

  logic [7:0] x8;
  logic [7:0] y8;
  logic [8:0] xs;
  logic       set_hit;
  logic       in_clip;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // scroll registers wrap modulo 256
  always_comb begin
    scroll_x_nxt = scroll_x_r;
    scroll_y_nxt = scroll_y_r;
    if (accept && in_mode == sfp_pkg::MODE_TICK) begin
      scroll_x_nxt = scroll_x_r + sfp_pkg::speed_x(cfg.speed_select[2:0]);
      scroll_y_nxt = scroll_y_r + sfp_pkg::speed_y(cfg.speed_select[5:3]);
    end
  end

  always_comb begin
    x8      = in_star_x + scroll_x_r;
    y8      = in_star_y + scroll_y_r;
    xs      = cfg.flip ? ({1'b0, x8} + sfp_pkg::FLIP_OFFSET) : {1'b0, x8};
    // set A is 0/1, set B is 2/3
    set_hit = (in_star_set == {1'b0, cfg.blink_a}) ||
              (in_star_set == {1'b1, cfg.blink_b});
    in_clip = (xs >= cfg.clip_min_x) && (xs <= cfg.clip_max_x) &&
              (y8 >= cfg.clip_min_y) && (y8 <= cfg.clip_max_y);

    pix_valid_nxt = (in_mode == sfp_pkg::MODE_STAR) && set_hit &&
                    (x8 < sfp_pkg::VISIBLE_LIMIT) && in_clip;
    pix_x_nxt     = pix_valid_nxt ? xs : '0;
    pix_y_nxt     = pix_valid_nxt ? y8 : '0;
    pix_col_nxt   = pix_valid_nxt ? (sfp_pkg::PEN_BASE + {4'd0, in_star_color}) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_x_r  <= '0;
      scroll_y_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      scroll_x_r <= scroll_x_nxt;
      scroll_y_r <= scroll_y_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_valid_r <= pix_valid_nxt;
      pix_x_r     <= pix_x_nxt;
      pix_y_r     <= pix_y_nxt;
      pix_col_r   <= pix_col_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_valid = pix_valid_r;
  assign out_pixel_x     = pix_x_r;
  assign out_pixel_y     = pix_y_r;
  assign out_pixel_color = pix_col_r;

endmodule

`default_nettype wire

// File: sv/sfp_regs.sv
// ----------------------------------------------------------------------------
// sfp_regs
// APB-style configuration registers of the star field plotter.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [sfp_pkg::AddrW-1:0] paddr,
  input  wire logic [sfp_pkg::DataW-1:0] pwdata,
  output logic      [sfp_pkg::DataW-1:0] prdata,
  output logic                           pready,
  output sfp_pkg::sfp_cfg_t              cfg
);

  sfp_pkg::sfp_cfg_t cfg_r;
  sfp_pkg::sfp_cfg_t cfg_nxt;
  logic [2:0]        idx;
  logic              wr_en;

  assign idx    = paddr[sfp_pkg::AddrW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        sfp_pkg::REG_BLINK_A:    cfg_nxt.blink_a      = pwdata[0];
        sfp_pkg::REG_BLINK_B:    cfg_nxt.blink_b      = pwdata[0];
        sfp_pkg::REG_SPEED_SEL:  cfg_nxt.speed_select = pwdata[5:0];
        sfp_pkg::REG_FLIP:       cfg_nxt.flip         = pwdata[0];
        sfp_pkg::REG_CLIP_MIN_X: cfg_nxt.clip_min_x   = pwdata[8:0];
        sfp_pkg::REG_CLIP_MAX_X: cfg_nxt.clip_max_x   = pwdata[8:0];
        sfp_pkg::REG_CLIP_MIN_Y: cfg_nxt.clip_min_y   = pwdata[7:0];
        sfp_pkg::REG_CLIP_MAX_Y: cfg_nxt.clip_max_y   = pwdata[7:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{blink_a:      1'b0,
                 blink_b:      1'b0,
                 speed_select: 6'd0,
                 flip:         1'b0,
                 clip_min_x:   9'd0,
                 clip_max_x:   sfp_pkg::CLIP_MAX_X_RST,
                 clip_min_y:   8'd0,
                 clip_max_y:   sfp_pkg::CLIP_MAX_Y_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      sfp_pkg::REG_BLINK_A:    prdata[0]   = cfg_r.blink_a;
      sfp_pkg::REG_BLINK_B:    prdata[0]   = cfg_r.blink_b;
      sfp_pkg::REG_SPEED_SEL:  prdata[5:0] = cfg_r.speed_select;
      sfp_pkg::REG_FLIP:       prdata[0]   = cfg_r.flip;
      sfp_pkg::REG_CLIP_MIN_X: prdata[8:0] = cfg_r.clip_min_x;
      sfp_pkg::REG_CLIP_MAX_X: prdata[8:0] = cfg_r.clip_max_x;
      sfp_pkg::REG_CLIP_MIN_Y: prdata[7:0] = cfg_r.clip_min_y;
      sfp_pkg::REG_CLIP_MAX_Y: prdata[7:0] = cfg_r.clip_max_y;
      default:                 prdata      = '0;
    endcase
  end

endmodule

`default_nettype wire
